// ===== design/srg_pkg.sv =====
// Package for the subtractive random generator: table geometry, constants,
// the sequencer state type and the structs passed between its modules.
// Depends on nothing.
`default_nettype none

package srg_pkg;

   localparam int unsigned TableDepth = 55;
   localparam int unsigned AddrWidth  = 6;
   localparam int unsigned DataWidth  = 30;
   localparam int unsigned SeedWidth  = 28;

   localparam logic [DataWidth-1:0] ModBig     = 30'd1000000000;
   localparam logic [SeedWidth-1:0] SeedBase   = 28'd161803398;
   localparam logic [AddrWidth-1:0] FillStride = 6'd21;
   localparam logic [AddrWidth-1:0] TableLast  = 6'd54;
   localparam logic [AddrWidth-1:0] TableSize  = 6'd55;
   localparam logic [AddrWidth-1:0] LagStart   = 6'd31;
   localparam logic [AddrWidth-1:0] LagOffset  = 6'd31;
   localparam logic [AddrWidth-1:0] LagWrap    = 6'd24;
   localparam logic [1:0]           LastPass   = 2'd3;

   localparam logic OpDraw   = 1'b0;
   localparam logic OpReseed = 1'b1;

   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [DataWidth-1:0] data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_INIT,
      ST_FILL_PERM,
      ST_WARM,
      ST_DRAW_RD
   } state_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      addr_type rd_addr_a;
      addr_type rd_addr_b;
   } mem_req_type;

   typedef struct packed {
      logic     valid;
      data_type sample;
      logic     reseeded;
   } result_type;

   // Difference of two residues modulo one billion.
   function automatic data_type sub_mod(input data_type a, input data_type b);
      logic [DataWidth:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[DataWidth]) begin
         return diff[DataWidth-1:0] + ModBig;
      end
      return diff[DataWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/srg_table.sv =====
// Lag table of the subtractive random generator: 55 words of 30 bits with
// one write port and two read ports, read data registered.
// Depends on srg_pkg.
`default_nettype none

module srg_table (
   input  wire                  clock,
   input  srg_pkg::mem_req_type mem_req,
   output srg_pkg::data_type    rd_data_a,
   output srg_pkg::data_type    rd_data_b
);

   srg_pkg::data_type table_ff [srg_pkg::TableDepth];
   srg_pkg::data_type rd_a_ff;
   srg_pkg::data_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         table_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_a_ff <= table_ff[mem_req.rd_addr_a];
      rd_b_ff <= table_ff[mem_req.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== design/srg_seq.sv =====
// Sequencer of the subtractive random generator: seeding passes, draw
// pointers and the read-modify-write path around the lag table.
// Depends on srg_pkg.
`default_nettype none

module srg_seq (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire                            req_opcode,
   input  wire  [srg_pkg::SeedWidth-1:0]  req_seed_magnitude,
   output srg_pkg::mem_req_type           mem_req,
   input  srg_pkg::data_type              rd_data_a,
   input  srg_pkg::data_type              rd_data_b,
   output srg_pkg::result_type            result
);

   srg_pkg::state_type state_ff, state_in;
   srg_pkg::addr_type  rp_ff, rp_in;
   srg_pkg::addr_type  lp_ff, lp_in;
   logic               seeded_ff, seeded_in;
   logic               reseeded_ff, reseeded_in;
   srg_pkg::data_type  prev_ff, prev_in;
   srg_pkg::data_type  cur_ff, cur_in;
   srg_pkg::addr_type  pos_ff, pos_in;
   srg_pkg::addr_type  cnt_ff, cnt_in;
   srg_pkg::addr_type  idx_ff, idx_in;
   logic [1:0]         pass_ff, pass_in;
   logic               wb_valid_ff, wb_valid_in;
   logic               wb_draw_ff, wb_draw_in;
   srg_pkg::addr_type  wb_addr_ff, wb_addr_in;

   logic                          need_fill;
   logic [srg_pkg::SeedWidth-1:0] seed_sat;
   srg_pkg::data_type             wb_diff;
   srg_pkg::addr_type             rp_adv;
   srg_pkg::addr_type             lp_adv;
   logic [srg_pkg::AddrWidth:0]   pos_sum;

   assign need_fill = (req_opcode == srg_pkg::OpReseed) || !seeded_ff;
   assign seed_sat  = (req_seed_magnitude > srg_pkg::SeedBase) ? srg_pkg::SeedBase
                                                               : req_seed_magnitude;
   assign wb_diff   = srg_pkg::sub_mod(rd_data_a, rd_data_b);
   assign rp_adv    = (rp_ff >= srg_pkg::TableSize) ? srg_pkg::addr_type'(1)
                                                    : rp_ff + srg_pkg::addr_type'(1);
   assign lp_adv    = (lp_ff >= srg_pkg::TableSize) ? srg_pkg::addr_type'(1)
                                                    : lp_ff + srg_pkg::addr_type'(1);
   assign pos_sum   = {1'b0, pos_ff} + {1'b0, srg_pkg::FillStride};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (start) begin
               state_in = need_fill ? srg_pkg::ST_FILL_INIT : srg_pkg::ST_DRAW_RD;
            end
         end
         srg_pkg::ST_FILL_INIT: begin
            state_in = srg_pkg::ST_FILL_PERM;
         end
         srg_pkg::ST_FILL_PERM: begin
            if (cnt_ff == srg_pkg::TableLast) begin
               state_in = srg_pkg::ST_WARM;
            end
         end
         srg_pkg::ST_WARM: begin
            if (pass_ff == srg_pkg::LastPass && idx_ff == srg_pkg::TableLast) begin
               state_in = srg_pkg::ST_DRAW_RD;
            end
         end
         srg_pkg::ST_DRAW_RD: begin
            state_in = srg_pkg::ST_IDLE;
         end
         default: begin
            state_in = srg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      rp_in       = rp_ff;
      lp_in       = lp_ff;
      seeded_in   = seeded_ff;
      reseeded_in = reseeded_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      pass_in     = pass_ff;
      wb_valid_in = 1'b0;
      wb_draw_in  = 1'b0;
      wb_addr_in  = wb_addr_ff;
      mem_req     = '0;
      case (state_ff)
         srg_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               reseeded_in = need_fill;
               prev_in     = srg_pkg::data_type'(srg_pkg::SeedBase - seed_sat);
            end
         end
         srg_pkg::ST_FILL_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = srg_pkg::TableLast;
            mem_req.wr_data = prev_ff;
            cur_in          = srg_pkg::data_type'(1);
            pos_in          = srg_pkg::FillStride;
            cnt_in          = srg_pkg::addr_type'(1);
         end
         srg_pkg::ST_FILL_PERM: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff - srg_pkg::addr_type'(1);
            mem_req.wr_data = cur_ff;
            cur_in          = srg_pkg::sub_mod(prev_ff, cur_ff);
            prev_in         = cur_ff;
            pos_in          = (pos_sum >= {1'b0, srg_pkg::TableSize})
                              ? pos_sum[srg_pkg::AddrWidth-1:0] - srg_pkg::TableSize
                              : pos_sum[srg_pkg::AddrWidth-1:0];
            cnt_in          = cnt_ff + srg_pkg::addr_type'(1);
            idx_in          = '0;
            pass_in         = '0;
         end
         srg_pkg::ST_WARM: begin
            mem_req.rd_addr_a = idx_ff;
            mem_req.rd_addr_b = (idx_ff >= srg_pkg::LagWrap) ? idx_ff - srg_pkg::LagWrap
                                                             : idx_ff + srg_pkg::LagOffset;
            wb_valid_in       = 1'b1;
            wb_addr_in        = idx_ff;
            if (idx_ff == srg_pkg::TableLast) begin
               idx_in  = '0;
               pass_in = pass_ff + 2'd1;
               if (pass_ff == srg_pkg::LastPass) begin
                  rp_in     = '0;
                  lp_in     = srg_pkg::LagStart;
                  seeded_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + srg_pkg::addr_type'(1);
            end
         end
         srg_pkg::ST_DRAW_RD: begin
            rp_in             = rp_adv;
            lp_in             = lp_adv;
            mem_req.rd_addr_a = rp_adv - srg_pkg::addr_type'(1);
            mem_req.rd_addr_b = lp_adv - srg_pkg::addr_type'(1);
            wb_valid_in       = 1'b1;
            wb_draw_in        = 1'b1;
            wb_addr_in        = rp_adv - srg_pkg::addr_type'(1);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
      if (wb_valid_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = wb_addr_ff;
         mem_req.wr_data = wb_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srg_pkg::ST_IDLE;
         rp_ff       <= '0;
         lp_ff       <= srg_pkg::LagStart;
         seeded_ff   <= 1'b0;
         wb_valid_ff <= 1'b0;
         wb_draw_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rp_ff       <= rp_in;
         lp_ff       <= lp_in;
         seeded_ff   <= seeded_in;
         wb_valid_ff <= wb_valid_in;
         wb_draw_ff  <= wb_draw_in;
      end
   end

   always_ff @(posedge clock) begin
      reseeded_ff <= reseeded_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pass_ff     <= pass_in;
      wb_addr_ff  <= wb_addr_in;
   end

   assign result.valid    = wb_valid_ff && wb_draw_ff;
   assign result.sample   = wb_diff;
   assign result.reseeded = reseeded_ff;

endmodule

`default_nettype wire

// ===== design/subtractive_random_generator_unit.sv =====
// Top level of the subtractive random generator: lag table, sequencer and
// the registered result port.
// Depends on srg_pkg, srg_table and srg_seq.
//
//   Port group   Direction  Handshake         Item
//   req_*        in         start, busy       opcode, seed magnitude
//   rsp_*        out        rsp_strobe        sample, reseeded flag
//
// An item is taken at an edge where start is high and busy is low.
// A draw holds busy while it reads the table, so a new item is taken only
// once the sequencer is back in idle; its result passes through the registered
// table read and then the result register on its way to the ports.
// A reseed, or the first item after reset, runs a 54-step fill and four
// 55-step passes, one table access per cycle, before its draw.
// Reset sets the pointers to their start values and clears the seeded state;
// the table holds no reset. Results cannot be held off; each is shown for one cycle with rsp_strobe.
`default_nettype none

module subtractive_random_generator_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire                            req_opcode,
   input  wire  [srg_pkg::SeedWidth-1:0]  req_seed_magnitude,
   output logic                           rsp_strobe,
   output logic [srg_pkg::DataWidth-1:0]  rsp_sample,
   output logic                           rsp_reseeded
);

   srg_pkg::mem_req_type mem_req;
   srg_pkg::data_type    rd_data_a;
   srg_pkg::data_type    rd_data_b;
   srg_pkg::result_type  result;

   logic              rsp_strobe_ff;
   srg_pkg::data_type rsp_sample_ff;
   logic              rsp_reseeded_ff;

   srg_table u_table (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   srg_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_seed_magnitude (req_seed_magnitude),
      .mem_req            (mem_req),
      .rd_data_a          (rd_data_a),
      .rd_data_b          (rd_data_b),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_sample_ff   <= result.sample;
         rsp_reseeded_ff <= result.reseeded;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_sample   = rsp_sample_ff;
   assign rsp_reseeded = rsp_reseeded_ff;

endmodule

`default_nettype wire
